// ===== rtl/att_pkg.sv =====
package att_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int KIND_BITS = 6;
	localparam int MAX_KW_LEN = 12;
	localparam int NUM_KW = 38;
	localparam int MAX_TOK = 3;
	localparam int BUF_IDX_BITS = $clog2(MAX_KW_LEN);

	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

	localparam logic [KIND_BITS-1:0] K_EQ = 6'd28;
	localparam logic [KIND_BITS-1:0] K_NEQ = 6'd29;
	localparam logic [KIND_BITS-1:0] K_ID = 6'd38;
	localparam logic [KIND_BITS-1:0] K_LABEL = 6'd39;
	localparam logic [KIND_BITS-1:0] K_NUMBER = 6'd40;
	localparam logic [KIND_BITS-1:0] K_STRING = 6'd41;
	localparam logic [KIND_BITS-1:0] K_ERROR = 6'd42;
	localparam logic [KIND_BITS-1:0] K_EOF = 6'd43;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_CHAR = 2'd1;
	localparam logic [1:0] E_OPER = 2'd2;
	localparam logic [1:0] E_STRING = 2'd3;

	typedef enum logic [2:0] {
		M_IDLE,
		M_COMMENT,
		M_WORD,
		M_INT,
		M_DOT,
		M_FRAC,
		M_SIGIL,
		M_STRING
	} mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [FIELD_BITS-1:0] length;
		logic [FIELD_BITS-1:0] line;
		logic [1:0] code;
	} tok_t;

	typedef logic [7:0] byte_t;

	// keyword text right aligned: first character in the highest used byte
	function automatic logic [8*MAX_KW_LEN-1:0] kw_text(input int k);
		logic [8*MAX_KW_LEN-1:0] t;
		t = '0;
		unique case (k)
			0: t = "true";
			1: t = "false";
			2: t = "nil";
			3: t = "push";
			4: t = "pop";
			5: t = "add";
			6: t = "sub";
			7: t = "mul";
			8: t = "div";
			9: t = "negate";
			10: t = "defglobal";
			11: t = "setglobal";
			12: t = "getglobal";
			13: t = "setlocal";
			14: t = "deflocal";
			15: t = "getlocal";
			16: t = "newscope";
			17: t = "endscope";
			18: t = "jump";
			19: t = "jump_if";
			20: t = {"back_", "jump"};
			21: t = {"back_", "jump_if"};
			22: t = "goto";
			23: t = "goto_if";
			24: t = "not";
			25: t = "and";
			26: t = "or";
			27: t = "xor";
			28: t = "eq";
			29: t = "neq";
			30: t = "gt";
			31: t = "lt";
			32: t = "gteq";
			33: t = "lteq";
			34: t = "concat";
			35: t = "print";
			36: t = "return";
			37: t = "exit";
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic int kw_len(input int k);
		int n;
		n = 0;
		for (int i = 0; i < MAX_KW_LEN; i++) begin
			if (kw_text(k)[8*i +: 8] != 8'd0) n = i + 1;
		end
		return n;
	endfunction

	function automatic logic is_digit(input byte_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word(input byte_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || is_digit(c);
	endfunction

endpackage

// ===== rtl/att_kwmatch.sv =====
module att_kwmatch (
	input  att_pkg::byte_t                        wbuf [att_pkg::MAX_KW_LEN],
	input  logic [att_pkg::FIELD_BITS-1:0]        wlen,
	input  logic                                  ovf,
	output logic [att_pkg::KIND_BITS-1:0]         kind,
	output logic [1:0]                            code
);

	logic hit [att_pkg::NUM_KW];
	logic found;
	logic [att_pkg::KIND_BITS-1:0] fkind;

	// every keyword compared in parallel
	always_comb begin
		for (int k = 0; k < att_pkg::NUM_KW; k++) begin
			hit[k] = (wlen == att_pkg::FIELD_BITS'(att_pkg::kw_len(k))) && !ovf;
			for (int i = 0; i < att_pkg::MAX_KW_LEN; i++) begin
				if (i < att_pkg::kw_len(k)) begin
					if (wbuf[i] != att_pkg::kw_text(k)[8*(att_pkg::kw_len(k)-1-i) +: 8])
						hit[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		found = 1'b0;
		fkind = '0;
		for (int k = att_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (hit[k]) begin
				found = 1'b1;
				fkind = att_pkg::KIND_BITS'(k);
			end
		end
	end

	always_comb begin
		code = att_pkg::E_NONE;
		if (found) begin
			kind = fkind;
		end else if (wlen >= 2 && wbuf[0] == "e" && wbuf[1] == "q") begin
			kind = att_pkg::K_EQ;
		end else if (wlen >= 3 && wbuf[0] == "n" && wbuf[1] == "e" && wbuf[2] == "q") begin
			kind = att_pkg::K_NEQ;
		end else begin
			kind = att_pkg::K_ERROR;
			code = att_pkg::E_OPER;
		end
	end

endmodule

// ===== rtl/att_scan.sv =====
module att_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  att_pkg::byte_t                    c,
	input  logic                              eot,
	output att_pkg::tok_t                     tok [att_pkg::MAX_TOK],
	output logic [1:0]                        tok_cnt
);

	localparam int OB = att_pkg::OFFSET_BITS;
	localparam int FB = att_pkg::FIELD_BITS;

	att_pkg::mode_t mode_q, mode_d;
	logic [OB-1:0] begin_q, begin_d, pos_q, pos_d;
	logic [FB-1:0] line_q, line_d;
	logic ovf_q, ovf_d, label_q, label_d;
	att_pkg::byte_t wbuf_q [att_pkg::MAX_KW_LEN];
	logic wr_en;
	logic [att_pkg::BUF_IDX_BITS-1:0] wr_idx;

	logic [OB-1:0] p_inc, dot;
	logic [FB-1:0] len_p, len_dot;
	logic [att_pkg::KIND_BITS-1:0] kw_kind;
	logic [1:0] kw_code;
	logic run_idle, line_inc;
	logic [1:0] n;

	function automatic logic [FB-1:0] tok_len(input logic [OB-1:0] e, input logic [OB-1:0] b);
		logic [OB-1:0] d;
		d = e - b;
		if (e <= b) return '0;
		if (OB > FB && d > OB'(att_pkg::FIELD_MAX)) return att_pkg::FIELD_MAX;
		return FB'(d);
	endfunction

	function automatic att_pkg::tok_t mk(input logic [att_pkg::KIND_BITS-1:0] k,
			input logic [OB-1:0] o, input logic [FB-1:0] l,
			input logic [FB-1:0] ln, input logic [1:0] cd);
		att_pkg::tok_t t;
		t.kind = k;
		t.offset = o;
		t.length = l;
		t.line = ln;
		t.code = cd;
		return t;
	endfunction

	assign p_inc = (pos_q < att_pkg::POS_MAX) ? pos_q + 1'b1 : pos_q;
	assign dot = (pos_q != '0) ? pos_q - 1'b1 : '0;
	assign len_p = tok_len(pos_q, begin_q);
	assign len_dot = tok_len(dot, begin_q);

	att_kwmatch u_kw (
		.wbuf (wbuf_q),
		.wlen (len_p),
		.ovf  (ovf_q),
		.kind (kw_kind),
		.code (kw_code)
	);

	always_comb begin
		mode_d = mode_q;
		begin_d = begin_q;
		pos_d = pos_q;
		ovf_d = ovf_q;
		label_d = label_q;
		wr_en = 1'b0;
		wr_idx = '0;
		run_idle = 1'b0;
		line_inc = 1'b0;
		n = '0;
		for (int i = 0; i < att_pkg::MAX_TOK; i++) tok[i] = '0;

		if (eot) begin
			unique case (mode_q)
				att_pkg::M_WORD: begin
					tok[n] = mk(kw_kind, begin_q, len_p, line_q, kw_code);
					n = n + 1'b1;
				end
				att_pkg::M_INT, att_pkg::M_FRAC: begin
					tok[n] = mk(att_pkg::K_NUMBER, begin_q, len_p, line_q, att_pkg::E_NONE);
					n = n + 1'b1;
				end
				att_pkg::M_DOT: begin
					tok[n] = mk(att_pkg::K_NUMBER, begin_q, len_dot, line_q, att_pkg::E_NONE);
					n = n + 1'b1;
					tok[n] = mk(att_pkg::K_ERROR, dot, FB'(1), line_q, att_pkg::E_CHAR);
					n = n + 1'b1;
				end
				att_pkg::M_SIGIL: begin
					tok[n] = mk(label_q ? att_pkg::K_LABEL : att_pkg::K_ID, begin_q, len_p,
						line_q, att_pkg::E_NONE);
					n = n + 1'b1;
				end
				att_pkg::M_STRING: begin
					tok[n] = mk(att_pkg::K_ERROR, begin_q, len_p, line_q, att_pkg::E_STRING);
					n = n + 1'b1;
				end
				default: ;
			endcase
			mode_d = att_pkg::M_IDLE;
			tok[n] = mk(att_pkg::K_EOF, pos_q, '0, line_q, att_pkg::E_NONE);
			n = n + 1'b1;
		end else begin
			unique case (mode_q)
				att_pkg::M_COMMENT: begin
					if (c == 8'h0a) run_idle = 1'b1;
				end
				att_pkg::M_WORD: begin
					if (att_pkg::is_word(c)) begin
						if (pos_q >= att_pkg::POS_MAX || len_p >= FB'(att_pkg::MAX_KW_LEN)) begin
							ovf_d = 1'b1;
						end else begin
							wr_en = 1'b1;
							wr_idx = len_p[att_pkg::BUF_IDX_BITS-1:0];
						end
					end else begin
						tok[n] = mk(kw_kind, begin_q, len_p, line_q, kw_code);
						n = n + 1'b1;
						run_idle = 1'b1;
					end
				end
				att_pkg::M_INT: begin
					if (c == ".") begin
						mode_d = att_pkg::M_DOT;
					end else if (!att_pkg::is_digit(c)) begin
						tok[n] = mk(att_pkg::K_NUMBER, begin_q, len_p, line_q, att_pkg::E_NONE);
						n = n + 1'b1;
						run_idle = 1'b1;
					end
				end
				att_pkg::M_DOT: begin
					if (att_pkg::is_digit(c)) begin
						mode_d = att_pkg::M_FRAC;
					end else begin
						// number ends before the dot, the dot itself is an error
						tok[n] = mk(att_pkg::K_NUMBER, begin_q, len_dot, line_q, att_pkg::E_NONE);
						n = n + 1'b1;
						tok[n] = mk(att_pkg::K_ERROR, dot, FB'(1), line_q, att_pkg::E_CHAR);
						n = n + 1'b1;
						run_idle = 1'b1;
					end
				end
				att_pkg::M_FRAC: begin
					if (!att_pkg::is_digit(c)) begin
						tok[n] = mk(att_pkg::K_NUMBER, begin_q, len_p, line_q, att_pkg::E_NONE);
						n = n + 1'b1;
						run_idle = 1'b1;
					end
				end
				att_pkg::M_SIGIL: begin
					if (!(att_pkg::is_word(c) || c == "$" || c == "-")) begin
						tok[n] = mk(label_q ? att_pkg::K_LABEL : att_pkg::K_ID, begin_q, len_p,
							line_q, att_pkg::E_NONE);
						n = n + 1'b1;
						run_idle = 1'b1;
					end
				end
				att_pkg::M_STRING: begin
					if (c == 8'h22) begin
						tok[n] = mk(att_pkg::K_STRING, begin_q, len_p, line_q, att_pkg::E_NONE);
						n = n + 1'b1;
						mode_d = att_pkg::M_IDLE;
					end else if (c == 8'h0a) begin
						line_inc = 1'b1;
					end
				end
				default: run_idle = 1'b1;
			endcase

			if (run_idle) begin
				mode_d = att_pkg::M_IDLE;
				case (c)
					8'h20, 8'h0d, 8'h09: ;
					8'h0a: line_inc = 1'b1;
					"#": mode_d = att_pkg::M_COMMENT;
					":", "$": begin
						begin_d = p_inc;
						label_d = (c == ":");
						mode_d = att_pkg::M_SIGIL;
					end
					8'h22: begin
						begin_d = p_inc;
						mode_d = att_pkg::M_STRING;
					end
					default: begin
						if (att_pkg::is_digit(c)) begin
							begin_d = pos_q;
							mode_d = att_pkg::M_INT;
						end else if (att_pkg::is_word(c)) begin
							begin_d = pos_q;
							wr_en = 1'b1;
							wr_idx = '0;
							ovf_d = 1'b0;
							mode_d = att_pkg::M_WORD;
						end else begin
							tok[n] = mk(att_pkg::K_ERROR, pos_q, FB'(1), line_q, att_pkg::E_CHAR);
							n = n + 1'b1;
						end
					end
				endcase
			end
			pos_d = p_inc;
		end
		line_d = (line_inc && line_q < att_pkg::FIELD_MAX) ? line_q + 1'b1 : line_q;
		tok_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= att_pkg::M_IDLE;
			begin_q <= '0;
			pos_q <= '0;
			line_q <= FB'(1);
			ovf_q <= 1'b0;
			label_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			begin_q <= begin_d;
			pos_q <= pos_d;
			line_q <= line_d;
			ovf_q <= ovf_d;
			label_q <= label_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) wbuf_q[wr_idx] <= c;
	end

endmodule

// ===== rtl/att_outq.sv =====
module att_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  att_pkg::tok_t          tok [att_pkg::MAX_TOK],
	input  logic [1:0]             tok_cnt,
	output logic                   free,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [55:0]            m_tdata,
	output logic [5:0]             m_tuser,
	output logic                   m_tlast
);

	att_pkg::tok_t tok_q [att_pkg::MAX_TOK];
	logic [1:0] cnt_q, idx_q;
	att_pkg::tok_t cur;

	assign m_tvalid = idx_q < cnt_q;
	assign free = (idx_q == cnt_q) || (m_tready && (idx_q + 2'd1 == cnt_q));
	assign cur = tok_q[idx_q];
	assign m_tuser = cur.kind;
	assign m_tdata = {6'd0, cur.code, cur.line, cur.length, cur.offset};
	assign m_tlast = (idx_q + 2'd1 == cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= tok_cnt;
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) tok_q <= tok;
	end

endmodule

// ===== rtl/assembly_text_tokenizer_top.sv =====
// an item accepted into the input register is scanned once the result register is free,
// and its first token is then registered in the result register, from which it can be taken
// throughput: one byte per cycle while each byte gives at most one token and m_tready is
// high; a byte that gives more tokens holds the input while the result register drains
// reset: arst_n clears scanner state to idle, position 0, line 1, and empties both registers
module assembly_text_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_byte
	input  logic        s_tuser,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // token_offset, token_length, token_line, error_code, pad
	output logic [5:0]  m_tuser,   // token_kind
	output logic        m_tlast    // last_of_run
);

	logic valid_s1;
	att_pkg::byte_t byte_s1;
	logic eot_s1;
	logic free, step;
	att_pkg::tok_t tok [att_pkg::MAX_TOK];
	logic [1:0] tok_cnt;

	assign step = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1 <= s_tuser;
		end
	end

	att_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.c       (byte_s1),
		.eot     (eot_s1),
		.tok     (tok),
		.tok_cnt (tok_cnt)
	);

	att_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step),
		.tok      (tok),
		.tok_cnt  (tok_cnt),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
